// ----- design/ttp_pkg.sv -----
// Package for the thermal tiered token pacer: constants, register map,
// and the command, status and configuration structs shared by the modules.
// No dependencies.
package ttp_pkg;

   localparam int TIME_BITS = 32;
   localparam int TEMP_BITS = 12;
   localparam int INTV_BITS = 24;
   localparam int BURST_BITS = 16;
   localparam int SLOPE_BITS = 24;
   localparam int CNT_BITS = 32;
   localparam int SUM_BITS = 48;
   localparam int TIER_BITS = 3;
   localparam int ADDR_BITS = 5;
   localparam int DATA_BITS = 32;

   localparam logic [TIME_BITS-1:0] SAMPLE_GAP_US = TIME_BITS'(50000);
   localparam int LOOKAHEAD_SHIFT = 2;

   // slope_q8 = dT(1/16 C) * 16000000 / dt_us
   localparam int MAG_BITS = TEMP_BITS;
   localparam logic [23:0] SLOPE_SCALE = 24'd16000000;
   localparam int DIV_BITS = MAG_BITS + 24;
   localparam int DIV_STEPS = DIV_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
   localparam logic [DIV_BITS-1:0] SLOPE_MAX = DIV_BITS'(8388607);

   localparam int EFF_BITS = SLOPE_BITS + LOOKAHEAD_SHIFT + 1;
   localparam logic signed [SLOPE_BITS-1:0] BOOST_MIN_Q8 = SLOPE_BITS'(77);
   localparam logic signed [EFF_BITS-1:0] T35_Q8 = EFF_BITS'(8960);
   localparam logic signed [EFF_BITS-1:0] T38_Q8 = EFF_BITS'(9728);
   localparam logic signed [EFF_BITS-1:0] T41_Q8 = EFF_BITS'(10496);

   localparam logic [TIER_BITS-1:0] TIER_BURST = 3'd0;
   localparam logic [TIER_BITS-1:0] TIER_COOL = 3'd1;
   localparam logic [TIER_BITS-1:0] TIER_WARM = 3'd2;
   localparam logic [TIER_BITS-1:0] TIER_HOT = 3'd3;
   localparam logic [TIER_BITS-1:0] TIER_CRITICAL = 3'd4;

   localparam logic [2:0] REG_BURST_TOKENS = 3'd0;
   localparam logic [2:0] REG_INTERVAL_COOL = 3'd1;
   localparam logic [2:0] REG_INTERVAL_WARM = 3'd2;
   localparam logic [2:0] REG_INTERVAL_HOT = 3'd3;
   localparam logic [2:0] REG_INTERVAL_CRITICAL = 3'd4;

   typedef struct packed {
      logic [BURST_BITS-1:0] burst_tokens;
      logic [INTV_BITS-1:0] interval_cool_us;
      logic [INTV_BITS-1:0] interval_warm_us;
      logic [INTV_BITS-1:0] interval_hot_us;
      logic [INTV_BITS-1:0] interval_critical_us;
   } ttp_cfg_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic sample;
      logic div_step;
      logic slope_wr;
      logic tier;
      logic gap;
      logic delay;
      logic commit;
   } ttp_cmd_type;

   typedef struct packed {
      logic do_slope;
      logic div_done;
      logic out_free;
   } ttp_status_type;

endpackage

// ----- design/ttp_ctrl.sv -----
// Controller of the token pacer: one-hot sequencer that steps the datapath
// through sampling, slope division, tier choice, wait and commit.
// Depends on ttp_pkg.
module ttp_ctrl import ttp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_opcode,
   input  ttp_status_type status,
   output ttp_cmd_type    cmd,
   output logic           req_stall
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SAMPLE = 8'b0000_0010,
      ST_DIVIDE = 8'b0000_0100,
      ST_SLOPE  = 8'b0000_1000,
      ST_TIER   = 8'b0001_0000,
      ST_GAP    = 8'b0010_0000,
      ST_DELAY  = 8'b0100_0000,
      ST_COMMIT = 8'b1000_0000
   } ttp_state_type;

   ttp_state_type state_ff;
   ttp_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_opcode) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_SAMPLE;
               end
            end
         end
         ST_SAMPLE: begin
            cmd.sample = 1'b1;
            state_in = status.do_slope ? ST_DIVIDE : ST_TIER;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_SLOPE;
            end
         end
         ST_SLOPE: begin
            cmd.slope_wr = 1'b1;
            state_in = ST_TIER;
         end
         ST_TIER: begin
            cmd.tier = 1'b1;
            state_in = ST_GAP;
         end
         ST_GAP: begin
            cmd.gap = 1'b1;
            state_in = ST_DELAY;
         end
         ST_DELAY: begin
            cmd.delay = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/ttp_datapath.sv -----
// Datapath of the token pacer: session state, slope multiplier and serial
// divider, tier and wait arithmetic, result register.
// Depends on ttp_pkg; driven by ttp_ctrl commands.
module ttp_datapath import ttp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  ttp_cmd_type                  cmd,
   input  ttp_cfg_type                  cfg,
   input  logic signed [TEMP_BITS-1:0]  req_temperature,
   input  logic [TIME_BITS-1:0]         req_now_us,
   input  logic                         rsp_stall,
   output ttp_status_type               status,
   output logic                         rsp_valid,
   output logic [INTV_BITS-1:0]         rsp_wait_us,
   output logic [TIME_BITS-1:0]         rsp_release_time,
   output logic [TIER_BITS-1:0]         rsp_tier,
   output logic                         rsp_paced,
   output logic [CNT_BITS-1:0]          rsp_token_total,
   output logic [CNT_BITS-1:0]          rsp_pause_total,
   output logic [SUM_BITS-1:0]          rsp_wait_sum_us
);

   // session state
   logic [CNT_BITS-1:0]          token_counter_ff, token_counter_in;
   logic [CNT_BITS-1:0]          pause_counter_ff, pause_counter_in;
   logic [SUM_BITS-1:0]          wait_acc_ff, wait_acc_in;
   logic signed [TEMP_BITS-1:0]  prev_temp_ff, prev_temp_in;
   logic signed [SLOPE_BITS-1:0] slope_ff, slope_in;
   logic [TIME_BITS-1:0]         sample_time_ff, sample_time_in;
   logic                         pending_ff, pending_in;
   logic [TIME_BITS-1:0]         last_release_ff, last_release_in;
   logic                         release_valid_ff, release_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // item payload and working registers
   logic signed [TEMP_BITS-1:0]  temp_ff;
   logic [TIME_BITS-1:0]         now_ff;
   logic [DIV_BITS-1:0]          div_quo_ff;
   logic [TIME_BITS-1:0]         div_rem_ff;
   logic [TIME_BITS-1:0]         divisor_ff;
   logic [DIV_CNT_BITS-1:0]      div_cnt_ff;
   logic                         sign_ff;
   logic [TIER_BITS-1:0]         tier_ff;
   logic [INTV_BITS-1:0]         interval_ff;
   logic [TIME_BITS-1:0]         elapsed_ff;
   logic [INTV_BITS-1:0]         wait_ff;

   logic [INTV_BITS-1:0]         rsp_wait_us_ff;
   logic [TIME_BITS-1:0]         rsp_release_time_ff;
   logic [TIER_BITS-1:0]         rsp_tier_ff;
   logic                         rsp_paced_ff;
   logic [CNT_BITS-1:0]          rsp_token_total_ff;
   logic [CNT_BITS-1:0]          rsp_pause_total_ff;
   logic [SUM_BITS-1:0]          rsp_wait_sum_us_ff;

   // combinational terms
   logic [TIME_BITS-1:0]         sample_gap;
   logic                         take_sample;
   logic                         slope_go;
   logic signed [TEMP_BITS:0]    delta_temp;
   logic [TEMP_BITS:0]           diff_neg;
   logic [MAG_BITS-1:0]          diff_mag;
   logic [DIV_BITS-1:0]          product;
   logic [TIME_BITS:0]           div_trial;
   logic                         div_fits;
   logic [TIME_BITS:0]           div_diff;
   logic [SLOPE_BITS-2:0]        slope_mag;
   logic signed [SLOPE_BITS-1:0] slope_new;
   logic                         burst_tok;
   logic                         boost;
   logic signed [EFF_BITS-1:0]   eff;
   logic [TIER_BITS-1:0]         tier_sel;
   logic [INTV_BITS-1:0]         interval_sel;
   logic [TIME_BITS-1:0]         elapsed_raw;
   logic [TIME_BITS-1:0]         elapsed_clip;
   logic                         must_wait;
   logic [INTV_BITS-1:0]         wait_sel;
   logic [TIME_BITS-1:0]         release_time;
   logic [CNT_BITS-1:0]          token_next;
   logic [CNT_BITS-1:0]          pause_next;
   logic [SUM_BITS:0]            acc_sum;
   logic [SUM_BITS-1:0]          acc_next;

   always_comb begin
      sample_gap = now_ff - sample_time_ff;
      take_sample = pending_ff || (sample_gap > SAMPLE_GAP_US);
      slope_go = take_sample && !pending_ff && (prev_temp_ff > $signed(TEMP_BITS'(0)));
      delta_temp = {temp_ff[TEMP_BITS-1], temp_ff} - {prev_temp_ff[TEMP_BITS-1], prev_temp_ff};
      diff_neg = -delta_temp;
      diff_mag = delta_temp[TEMP_BITS] ? diff_neg[MAG_BITS-1:0] : delta_temp[MAG_BITS-1:0];
      product = DIV_BITS'(diff_mag) * DIV_BITS'(SLOPE_SCALE);

      div_trial = {div_rem_ff, div_quo_ff[DIV_BITS-1]};
      div_fits = div_trial >= {1'b0, divisor_ff};
      div_diff = div_trial - {1'b0, divisor_ff};

      slope_mag = (div_quo_ff > SLOPE_MAX) ? SLOPE_MAX[SLOPE_BITS-2:0]
                                           : div_quo_ff[SLOPE_BITS-2:0];
      slope_new = sign_ff ? -$signed({1'b0, slope_mag}) : $signed({1'b0, slope_mag});

      burst_tok = token_counter_ff < CNT_BITS'(cfg.burst_tokens);
      boost = slope_ff >= BOOST_MIN_Q8;
      eff = $signed(EFF_BITS'({{(EFF_BITS-TEMP_BITS-4){temp_ff[TEMP_BITS-1]}}, temp_ff, 4'b0000}));
      if (boost) begin
         eff = eff + $signed({slope_ff[SLOPE_BITS-1], slope_ff, {LOOKAHEAD_SHIFT{1'b0}}});
      end
      priority if (burst_tok) begin
         tier_sel = TIER_BURST;
         interval_sel = '0;
      end else if (eff > T41_Q8) begin
         tier_sel = TIER_CRITICAL;
         interval_sel = cfg.interval_critical_us;
      end else if (eff > T38_Q8) begin
         tier_sel = TIER_HOT;
         interval_sel = cfg.interval_hot_us;
      end else if (eff > T35_Q8) begin
         tier_sel = TIER_WARM;
         interval_sel = cfg.interval_warm_us;
      end else begin
         tier_sel = TIER_COOL;
         interval_sel = cfg.interval_cool_us;
      end

      elapsed_raw = now_ff - last_release_ff;
      elapsed_clip = elapsed_raw[TIME_BITS-1] ? '0 : elapsed_raw;
      must_wait = (interval_ff != '0) && release_valid_ff
                  && (elapsed_ff < TIME_BITS'(interval_ff));
      wait_sel = must_wait ? (interval_ff - elapsed_ff[INTV_BITS-1:0]) : '0;

      release_time = now_ff + TIME_BITS'(wait_ff);
      token_next = (token_counter_ff == '1) ? token_counter_ff : token_counter_ff + 1'b1;
      pause_next = ((wait_ff == '0) || (pause_counter_ff == '1)) ? pause_counter_ff
                                                                 : pause_counter_ff + 1'b1;
      acc_sum = {1'b0, wait_acc_ff} + (SUM_BITS+1)'(wait_ff);
      acc_next = acc_sum[SUM_BITS] ? '1 : acc_sum[SUM_BITS-1:0];
   end

   always_comb begin
      token_counter_in = token_counter_ff;
      pause_counter_in = pause_counter_ff;
      wait_acc_in = wait_acc_ff;
      prev_temp_in = prev_temp_ff;
      slope_in = slope_ff;
      sample_time_in = sample_time_ff;
      pending_in = pending_ff;
      last_release_in = last_release_ff;
      release_valid_in = release_valid_ff;
      if (cmd.clear) begin
         token_counter_in = '0;
         pause_counter_in = '0;
         wait_acc_in = '0;
         prev_temp_in = '0;
         slope_in = '0;
         sample_time_in = '0;
         pending_in = 1'b1;
         last_release_in = '0;
         release_valid_in = 1'b0;
      end
      if (cmd.sample && take_sample) begin
         prev_temp_in = temp_ff;
         sample_time_in = now_ff;
         pending_in = 1'b0;
      end
      if (cmd.slope_wr) begin
         slope_in = slope_new;
      end
      if (cmd.commit) begin
         token_counter_in = token_next;
         pause_counter_in = pause_next;
         wait_acc_in = acc_next;
         last_release_in = release_time;
         release_valid_in = 1'b1;
      end
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_counter_ff <= '0;
         pause_counter_ff <= '0;
         wait_acc_ff <= '0;
         prev_temp_ff <= '0;
         slope_ff <= '0;
         sample_time_ff <= '0;
         pending_ff <= 1'b1;
         last_release_ff <= '0;
         release_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         token_counter_ff <= token_counter_in;
         pause_counter_ff <= pause_counter_in;
         wait_acc_ff <= wait_acc_in;
         prev_temp_ff <= prev_temp_in;
         slope_ff <= slope_in;
         sample_time_ff <= sample_time_in;
         pending_ff <= pending_in;
         last_release_ff <= last_release_in;
         release_valid_ff <= release_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         temp_ff <= req_temperature;
         now_ff <= req_now_us;
      end
      if (cmd.sample) begin
         div_quo_ff <= product;
         div_rem_ff <= '0;
         divisor_ff <= sample_gap;
         div_cnt_ff <= '0;
         sign_ff <= delta_temp[TEMP_BITS];
      end
      if (cmd.div_step) begin
         div_rem_ff <= div_fits ? div_diff[TIME_BITS-1:0] : div_trial[TIME_BITS-1:0];
         div_quo_ff <= {div_quo_ff[DIV_BITS-2:0], div_fits};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.tier) begin
         tier_ff <= tier_sel;
         interval_ff <= interval_sel;
      end
      if (cmd.gap) begin
         elapsed_ff <= elapsed_clip;
      end
      if (cmd.delay) begin
         wait_ff <= wait_sel;
      end
      if (cmd.commit) begin
         rsp_wait_us_ff <= wait_ff;
         rsp_release_time_ff <= release_time;
         rsp_tier_ff <= tier_ff;
         rsp_paced_ff <= (wait_ff != '0);
         rsp_token_total_ff <= token_next;
         rsp_pause_total_ff <= pause_next;
         rsp_wait_sum_us_ff <= acc_next;
      end
   end

   assign status.do_slope = slope_go;
   assign status.div_done = (div_cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_wait_us = rsp_wait_us_ff;
   assign rsp_release_time = rsp_release_time_ff;
   assign rsp_tier = rsp_tier_ff;
   assign rsp_paced = rsp_paced_ff;
   assign rsp_token_total = rsp_token_total_ff;
   assign rsp_pause_total = rsp_pause_total_ff;
   assign rsp_wait_sum_us = rsp_wait_sum_us_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("result committed over an undelivered beat");

   a_pause_le_token: assert property (@(posedge clock) disable iff (reset)
      pause_counter_ff <= token_counter_ff)
      else $error("pause count exceeds token count");

   a_paced_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_paced_ff == (rsp_wait_us_ff != '0)))
      else $error("paced flag disagrees with wait");

   a_release_track: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (release_valid_ff && (last_release_ff == rsp_release_time_ff)))
      else $error("last release time not updated on commit");

endmodule

// ----- design/thermal_tiered_token_pacer.sv -----
// A token request steps through sample, tier, gap, delay and commit; when a new slope
// is computed, the 36-step serial divider and a slope write follow the sample. Commit waits
// while an undelivered result is stalled; the next request is taken once back in idle.
// A session start is taken in idle and gives no result.
// Reset (synchronous) clears configuration and session state; no clearing pass.
// Depends on ttp_pkg, ttp_ctrl and ttp_datapath.
module thermal_tiered_token_pacer import ttp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic signed [TEMP_BITS-1:0]  req_temperature,
   input  logic [TIME_BITS-1:0]         req_now_us,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [INTV_BITS-1:0]         rsp_wait_us,
   output logic [TIME_BITS-1:0]         rsp_release_time,
   output logic [TIER_BITS-1:0]         rsp_tier,
   output logic                         rsp_paced,
   output logic [CNT_BITS-1:0]          rsp_token_total,
   output logic [CNT_BITS-1:0]          rsp_pause_total,
   output logic [SUM_BITS-1:0]          rsp_wait_sum_us,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ADDR_BITS-1:0]         paddr,
   input  logic [DATA_BITS-1:0]         pwdata,
   output logic [DATA_BITS-1:0]         prdata,
   output logic                         pready
);

   ttp_cfg_type    cfg_ff;
   ttp_cfg_type    cfg_in;
   ttp_cmd_type    cmd;
   ttp_status_type status;
   logic           csr_write;
   logic [2:0]     csr_index;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[ADDR_BITS-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BURST_TOKENS: cfg_in.burst_tokens = pwdata[BURST_BITS-1:0];
            REG_INTERVAL_COOL: cfg_in.interval_cool_us = pwdata[INTV_BITS-1:0];
            REG_INTERVAL_WARM: cfg_in.interval_warm_us = pwdata[INTV_BITS-1:0];
            REG_INTERVAL_HOT: cfg_in.interval_hot_us = pwdata[INTV_BITS-1:0];
            REG_INTERVAL_CRITICAL: cfg_in.interval_critical_us = pwdata[INTV_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BURST_TOKENS: prdata = DATA_BITS'(cfg_ff.burst_tokens);
         REG_INTERVAL_COOL: prdata = DATA_BITS'(cfg_ff.interval_cool_us);
         REG_INTERVAL_WARM: prdata = DATA_BITS'(cfg_ff.interval_warm_us);
         REG_INTERVAL_HOT: prdata = DATA_BITS'(cfg_ff.interval_hot_us);
         REG_INTERVAL_CRITICAL: prdata = DATA_BITS'(cfg_ff.interval_critical_us);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ttp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .req_stall  (req_stall)
   );

   ttp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg_ff),
      .req_temperature  (req_temperature),
      .req_now_us       (req_now_us),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_wait_us      (rsp_wait_us),
      .rsp_release_time (rsp_release_time),
      .rsp_tier         (rsp_tier),
      .rsp_paced        (rsp_paced),
      .rsp_token_total  (rsp_token_total),
      .rsp_pause_total  (rsp_pause_total),
      .rsp_wait_sum_us  (rsp_wait_sum_us)
   );

endmodule
